// ----- rtl/core/wwva_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwva_pkg
// Shared types, constants and the arctangent table of the wind window core.
// ----------------------------------------------------------------------------
package wwva_pkg;

  // window store and cordic length
  localparam int WINDOW_DEPTH = 200;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_IDX_W   = 5;

  // derived widths
  localparam int ADDR_W    = $clog2(WINDOW_DEPTH);
  localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
  localparam int STEP_W    = $clog2(CORDIC_STEPS);
  localparam int SUM_W     = 16 + CNT_W;
  localparam int DIV_CNT_W = $clog2(SUM_W);
  localparam int TRIG_W    = 18;
  localparam int PROD_W    = 17 + TRIG_W;
  localparam int ACC_W     = 42;
  localparam int SC_W      = 34;
  localparam int Z_W       = 26;
  localparam int V_W       = 46;

  // angles in degrees with 16 fraction bits
  localparam logic signed [Z_W-1:0] DEG90  = 26'sd5898240;
  localparam logic signed [Z_W-1:0] DEG180 = 26'sd11796480;
  localparam logic signed [Z_W-1:0] DEG360 = 26'sd23592960;

  localparam logic [15:0]            DIR_FULL    = 16'd46080;
  localparam logic signed [SC_W-1:0] CORDIC_UNIT = 34'sd652032874;
  localparam logic signed [V_W-1:0]  NORM_LIMIT  = 46'sh100_0000_0000;
  localparam logic [7:0]             WLEN_RESET  = 8'd200;

  typedef struct packed {
    logic [15:0] wind_speed;
    logic [15:0] wind_direction;
  } in_t;

  typedef struct packed {
    logic [15:0] mean_speed;
    logic [15:0] peak_speed;
    logic [15:0] mean_direction;
    logic [7:0]  sample_count;
  } out_t;

  // one window entry: speed with its precomputed cosine and sine
  typedef struct packed {
    logic [15:0]              speed;
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } ring_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG,
    ST_STORE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH,
    ST_WAIT,
    ST_OUT
  } core_state_t;

  typedef enum logic [1:0] {
    VA_IDLE,
    VA_NORM,
    VA_ROTATE,
    VA_FINISH
  } vang_state_t;

  // atan(2^-i) in degrees, 16 fraction bits, rounded
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] r;
    case (idx)
      5'd0:    r = 26'sd2949120;
      5'd1:    r = 26'sd1740967;
      5'd2:    r = 26'sd919879;
      5'd3:    r = 26'sd466945;
      5'd4:    r = 26'sd234379;
      5'd5:    r = 26'sd117304;
      5'd6:    r = 26'sd58666;
      5'd7:    r = 26'sd29335;
      5'd8:    r = 26'sd14668;
      5'd9:    r = 26'sd7334;
      5'd10:   r = 26'sd3667;
      5'd11:   r = 26'sd1833;
      5'd12:   r = 26'sd917;
      5'd13:   r = 26'sd458;
      5'd14:   r = 26'sd229;
      5'd15:   r = 26'sd115;
      5'd16:   r = 26'sd57;
      5'd17:   r = 26'sd29;
      5'd18:   r = 26'sd14;
      5'd19:   r = 26'sd7;
      5'd20:   r = 26'sd4;
      5'd21:   r = 26'sd2;
      5'd22:   r = 26'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/wwva_sincos.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwva_sincos
// Iterative rotation cordic: cosine and sine of one direction, one step a cycle.
// ----------------------------------------------------------------------------
module wwva_sincos (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [15:0]                        dir,
  output logic                               done,
  output logic signed [wwva_pkg::TRIG_W-1:0] cos_v,
  output logic signed [wwva_pkg::TRIG_W-1:0] sin_v
);
  import wwva_pkg::*;

  logic                   busy;
  logic [STEP_W-1:0]      step;
  logic signed [SC_W-1:0] x, y, x_next, y_next;
  logic signed [Z_W-1:0]  z, z_next, z_fold;
  logic                   flip, flip_fold;
  logic signed [TRIG_W-1:0] xs, ys;

  // fold the start angle into -90..90 degrees
  always_comb begin
    logic signed [Z_W-1:0] z_in, z_wrap;
    z_in   = $signed({1'b0, dir, 9'b0});
    z_wrap = (z_in > DEG180) ? z_in - DEG360 : z_in;
    if (z_wrap > DEG90) begin
      z_fold    = z_wrap - DEG180;
      flip_fold = 1'b1;
    end else if (z_wrap < -DEG90) begin
      z_fold    = z_wrap + DEG180;
      flip_fold = 1'b1;
    end else begin
      z_fold    = z_wrap;
      flip_fold = 1'b0;
    end
  end

  // one rotation step
  always_comb begin
    logic signed [SC_W-1:0] dx, dy;
    logic signed [Z_W-1:0]  ang;
    dx  = y >>> step;
    dy  = x >>> step;
    ang = atan_q16(ATAN_IDX_W'(step));
    if (z >= 0) begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - ang;
    end else begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + ang;
    end
  end

  // step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        x    <= CORDIC_UNIT;
        y    <= '0;
        z    <= z_fold;
        flip <= flip_fold;
      end else if (busy) begin
        x    <= x_next;
        y    <= y_next;
        z    <= z_next;
        step <= step + 1'b1;
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // scale to fifteen fraction bits and undo the fold
  assign xs    = TRIG_W'(x >>> 15);
  assign ys    = TRIG_W'(y >>> 15);
  assign cos_v = flip ? -xs : xs;
  assign sin_v = flip ? -ys : ys;

endmodule

// ----- rtl/core/wwva_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwva_div
// Bit-serial restoring divider: window speed sum over sample count.
// ----------------------------------------------------------------------------
module wwva_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [wwva_pkg::SUM_W-1:0]     dividend,
  input  logic [wwva_pkg::CNT_W-1:0]     divisor,
  output logic                           done,
  output logic [15:0]                    quotient
);
  import wwva_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [SUM_W-1:0]     sh;
  logic [CNT_W-1:0]     rem, dvs;
  logic [CNT_W:0]       trial, diff;
  logic                 ge;

  // one quotient bit a cycle
  assign trial = {rem, sh[SUM_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        sh   <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= ge ? CNT_W'(diff) : CNT_W'(trial);
        sh  <= {sh[SUM_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = sh[15:0];

endmodule

// ----- rtl/core/wwva_vang.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwva_vang
// Vector angle: normalising shift one bit a cycle, then vectoring cordic.
// ----------------------------------------------------------------------------
module wwva_vang (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [wwva_pkg::ACC_W-1:0] xin,
  input  logic signed [wwva_pkg::ACC_W-1:0] yin,
  output logic                              done,
  output logic [15:0]                       angle
);
  import wwva_pkg::*;

  vang_state_t           state, state_next;
  logic signed [V_W-1:0] x, y, x_next, y_next;
  logic signed [Z_W-1:0] z, z_next;
  logic [STEP_W-1:0]     step;
  logic                  small_v, last_step, is_zero;
  logic [15:0]           angle_fin;

  assign is_zero   = (xin == '0) && (yin == '0);
  assign small_v   = (x < NORM_LIMIT) && (x > -NORM_LIMIT) &&
                     (y < NORM_LIMIT) && (y > -NORM_LIMIT);
  assign last_step = step == STEP_W'(CORDIC_STEPS - 1);

  // one vectoring step
  always_comb begin
    logic signed [V_W-1:0] dx, dy;
    logic signed [Z_W-1:0] ang;
    dx  = y >>> step;
    dy  = x >>> step;
    ang = atan_q16(ATAN_IDX_W'(step));
    if (y >= 0) begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + ang;
    end else begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - ang;
    end
  end

  // wrap to 0..360 and round to seven fraction bits
  always_comb begin
    logic signed [Z_W-1:0] zp;
    logic [Z_W:0]          rounded;
    logic [17:0]           q;
    zp        = (z < 0) ? z + DEG360 : z;
    rounded   = {1'b0, zp} + (Z_W + 1)'(256);
    q         = rounded[Z_W:9];
    angle_fin = (q >= {2'b0, DIR_FULL}) ? 16'(q - {2'b0, DIR_FULL}) : 16'(q);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      VA_IDLE:   if (start && !is_zero) state_next = VA_NORM;
      VA_NORM:   if (!small_v) state_next = VA_ROTATE;
      VA_ROTATE: if (last_step) state_next = VA_FINISH;
      VA_FINISH: state_next = VA_IDLE;
      default:   state_next = VA_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= VA_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        VA_IDLE: if (start) begin
          x <= V_W'(xin);
          y <= V_W'(yin);
          z <= '0;
          if (is_zero) begin
            angle <= '0;
            done  <= 1'b1;
          end
        end
        VA_NORM: begin
          step <= '0;
          if (small_v) begin
            x <= x <<< 1;
            y <= y <<< 1;
          end else if (x < 0) begin
            // quarter turn into the right half-plane
            if (y >= 0) begin
              x <= y;
              y <= -x;
              z <= DEG90;
            end else begin
              x <= -y;
              y <= x;
              z <= -DEG90;
            end
          end
        end
        VA_ROTATE: begin
          x    <= x_next;
          y    <= y_next;
          z    <= z_next;
          step <= step + 1'b1;
        end
        VA_FINISH: begin
          angle <= angle_fin;
          done  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/wind_window_vector_average_core.sv -----
// handshake: one request at a time; a new one is taken only while the core is idle, after the
//   result of the last one has gone into the output register; each request is held by
//   the window walk reading one ring entry per cycle, the divider and the angle unit,
//   and an output stall holds the core until the output register is free
// reset: control, write pointer and fill count cleared, window_length set to 200
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wind_window_vector_average_core
// Sliding-window wind statistics: mean and peak speed, vector-mean direction.
// ----------------------------------------------------------------------------
module wind_window_vector_average_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  wwva_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output wwva_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [7:0]      cfg_data
);
  import wwva_pkg::*;

  core_state_t state, state_next;

  logic [7:0]        window_length;
  logic [ADDR_W-1:0] wp, pos;
  logic [CNT_W-1:0]  fill, win_n, walk_cnt, fill_inc, len_eff;
  logic [15:0]       spd_q, dir_red;
  logic              issue, sc_start, fin_start, accept;

  ring_entry_t       ring [WINDOW_DEPTH];
  ring_entry_t       rd_q, wr_entry;
  logic              rd_v;

  logic [15:0]              prod_spd;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic                     prod_v;

  logic [SUM_W-1:0]        sum_acc;
  logic [15:0]             peak;
  logic signed [ACC_W-1:0] xsum, ysum;

  logic                     sc_done;
  logic signed [TRIG_W-1:0] sc_cos, sc_sin;
  logic                     div_done, ang_done, div_fin, ang_fin;
  logic [15:0]              quotient, angle;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign dir_red   = (in_data.wind_direction >= DIR_FULL) ?
                     in_data.wind_direction - DIR_FULL : in_data.wind_direction;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WLEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window_length <= cfg_data;
    end
  end

  // effective window length and updated fill count
  always_comb begin
    if (window_length == 8'd0) begin
      len_eff = CNT_W'(1);
    end else if (int'(window_length) > WINDOW_DEPTH) begin
      len_eff = CNT_W'(WINDOW_DEPTH);
    end else begin
      len_eff = CNT_W'(window_length);
    end
    fill_inc = (fill < CNT_W'(WINDOW_DEPTH)) ? fill + 1'b1 : fill;
  end

  // next state and control
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    issue      = 1'b0;
    sc_start   = 1'b0;
    fin_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          sc_start   = 1'b1;
          state_next = ST_TRIG;
        end
      end
      ST_TRIG:  if (sc_done) state_next = ST_STORE;
      ST_STORE: state_next = ST_WALK;
      ST_WALK: begin
        issue = 1'b1;
        if (walk_cnt == win_n - 1'b1) state_next = ST_DRAIN;
      end
      ST_DRAIN: if (!rd_v && !prod_v) state_next = ST_FINISH;
      ST_FINISH: begin
        fin_start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: if (div_fin && ang_fin) state_next = ST_OUT;
      ST_OUT:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pointers and window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      fill    <= '0;
      div_fin <= 1'b0;
      ang_fin <= 1'b0;
    end else begin
      if (accept) spd_q <= in_data.wind_speed;
      if (state == ST_STORE) begin
        pos      <= wp;
        wp       <= (wp == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : wp + 1'b1;
        fill     <= fill_inc;
        win_n    <= (fill_inc < len_eff) ? fill_inc : len_eff;
        walk_cnt <= '0;
      end
      if (issue) begin
        pos      <= (pos == '0) ? ADDR_W'(WINDOW_DEPTH - 1) : pos - 1'b1;
        walk_cnt <= walk_cnt + 1'b1;
      end
      if (fin_start) begin
        div_fin <= 1'b0;
        ang_fin <= 1'b0;
      end else begin
        if (div_done) div_fin <= 1'b1;
        if (ang_done) ang_fin <= 1'b1;
      end
    end
  end

  // window ring: new entry written once, walked newest first
  assign wr_entry = '{speed: spd_q, cos_v: sc_cos, sin_v: sc_sin};

  always_ff @(posedge clk) begin
    if (state == ST_STORE) ring[wp] <= wr_entry;
    rd_q <= ring[pos];
  end

  // read and product pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v   <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      rd_v   <= issue;
      prod_v <= rd_v;
    end
  end

  // speed-weighted trig products
  always_ff @(posedge clk) begin
    prod_spd <= rd_q.speed;
    prod_x   <= $signed({1'b0, rd_q.speed}) * rd_q.cos_v;
    prod_y   <= $signed({1'b0, rd_q.speed}) * rd_q.sin_v;
  end

  // window accumulators
  always_ff @(posedge clk) begin
    if (state == ST_STORE) begin
      sum_acc <= '0;
      peak    <= '0;
      xsum    <= '0;
      ysum    <= '0;
    end else if (prod_v) begin
      sum_acc <= sum_acc + SUM_W'(prod_spd);
      if (prod_spd > peak) peak <= prod_spd;
      xsum <= xsum + ACC_W'(prod_x);
      ysum <= ysum + ACC_W'(prod_y);
    end
  end

  wwva_sincos u_sincos (
    .clk   (clk),
    .rst   (rst),
    .start (sc_start),
    .dir   (dir_red),
    .done  (sc_done),
    .cos_v (sc_cos),
    .sin_v (sc_sin)
  );

  wwva_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (fin_start),
    .dividend (sum_acc),
    .divisor  (win_n),
    .done     (div_done),
    .quotient (quotient)
  );

  wwva_vang u_vang (
    .clk   (clk),
    .rst   (rst),
    .start (fin_start),
    .xin   (xsum),
    .yin   (ysum),
    .done  (ang_done),
    .angle (angle)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_valid               <= 1'b1;
      out_data.mean_speed     <= quotient;
      out_data.peak_speed     <= peak;
      out_data.mean_direction <= angle;
      out_data.sample_count   <= 8'(win_n);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // checks
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.sample_count != 8'd0)
    else $error("result with empty window");

  a_mean_le_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.mean_speed <= out_data.peak_speed)
    else $error("mean speed above peak speed");

  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.mean_direction < DIR_FULL)
    else $error("direction out of range");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(WINDOW_DEPTH) && wp < ADDR_W'(WINDOW_DEPTH))
    else $error("ring bookkeeping out of range");

endmodule

// ----- tb/wind_window_vector_average_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wind_window_vector_average_core_tb
// Drives wind sample requests with random idling on both channels and checks
// every statistics result against a cycle-free model of the window, with
// window_length changed between phases while the core is idle.
// ----------------------------------------------------------------------------
module wind_window_vector_average_core_tb;
  import wwva_pkg::*;

  localparam int DEPTH   = 200;
  localparam int NSTEP   = 16;
  localparam int SETTLE  = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;

  wind_window_vector_average_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // model state
  logic [15:0] spd_hist [DEPTH];
  logic [15:0] dir_hist [DEPTH];
  int unsigned wr_ptr = 0;
  int unsigned filled = 0;
  int unsigned win_len = 200;

  in_t  sample_q [$];
  out_t stats_q  [$];
  int   errors = 0;
  bit   calm = 1'b0;
  bit   hold_send = 1'b0;
  bit   in_taken = 1'b0;
  int   send_gap = 0;
  int   recv_gap = 0;

  longint atan_tab [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
    4, 2, 1, 0};

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  // cosine and sine of a q9.7 direction, each q.15
  function automatic void trig(input int unsigned d, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(d) * 512; x = 652032874; y = 0; flip = 0;
    if (z > 11796480) z -= 23592960;
    if (z > 5898240) begin
      z -= 11796480; flip = 1;
    end else if (z < -5898240) begin
      z += 11796480; flip = 1;
    end
    for (int i = 0; i < NSTEP; i++) begin
      dx = fshr(y, i); dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    x = fshr(x, 15); y = fshr(y, 15);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [15:0] heading(longint x, longint y);
    longint z, t, dx, dy, q;
    z = 0;
    if (x == 0 && y == 0) return 16'd0;
    while (absl(x) < (64'sd1 <<< 40) && absl(y) < (64'sd1 <<< 40)) begin
      x *= 2; y *= 2;
    end
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 5898240;
      end else begin
        t = x; x = -y; y = t; z = -5898240;
      end
    end
    for (int i = 0; i < NSTEP; i++) begin
      dx = fshr(y, i); dy = fshr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_tab[i];
      end else begin
        x -= dx; y += dy; z -= atan_tab[i];
      end
    end
    while (z < 0) z += 23592960;
    q = (z + 256) >>> 9;
    while (q >= 46080) q -= 46080;
    return q[15:0];
  endfunction

  // push a sample and work out the window statistics
  function automatic out_t window_stats(in_t smp);
    int unsigned d, len, n, pos, peak;
    longint sum, xs, ys, c, s;
    out_t r;
    d = smp.wind_direction;
    if (d >= 46080) d -= 46080;
    spd_hist[wr_ptr] = smp.wind_speed;
    dir_hist[wr_ptr] = d;
    wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
    if (filled < DEPTH) filled++;
    len = win_len;
    if (len < 1) len = 1;
    if (len > DEPTH) len = DEPTH;
    n = filled < len ? filled : len;
    pos = wr_ptr; sum = 0; xs = 0; ys = 0; peak = 0;
    for (int k = 0; k < n; k++) begin
      pos = (pos == 0) ? DEPTH - 1 : pos - 1;
      sum += spd_hist[pos];
      if (spd_hist[pos] > peak) peak = spd_hist[pos];
      trig(dir_hist[pos], c, s);
      xs += longint'(spd_hist[pos]) * c;
      ys += longint'(spd_hist[pos]) * s;
    end
    r.mean_speed     = 16'(sum / n);
    r.peak_speed     = 16'(peak);
    r.mean_direction = heading(xs, ys);
    r.sample_count   = 8'(n);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // append a request to the pending queue
  task automatic queue_sample(input in_t s);
    sample_q.insert(sample_q.size(), s);
  endtask

  // request driver and result back-pressure
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        void'(sample_q.pop_front());
        if (!calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 13);
      end
      if (!in_valid || in_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!hold_send && sample_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= sample_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      in_taken = 1'b0;
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(1, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // predict on accepted requests, check on accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        stats_q.insert(stats_q.size(), window_stats(in_data));
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (stats_q.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          out_t e;
          e = stats_q.pop_front();
          if (out_data.mean_speed != e.mean_speed)
            report_mismatch("mean_speed", out_data.mean_speed, e.mean_speed);
          if (out_data.peak_speed != e.peak_speed)
            report_mismatch("peak_speed", out_data.peak_speed, e.peak_speed);
          if (out_data.mean_direction != e.mean_direction)
            report_mismatch("mean_direction", out_data.mean_direction,
                            e.mean_direction);
          if (out_data.sample_count != e.sample_count)
            report_mismatch("sample_count", out_data.sample_count, e.sample_count);
        end
      end
    end
  end

  task automatic wait_idle();
    while (sample_q.size() > 0 || stats_q.size() > 0 || in_valid) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_len(input logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    win_len = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_t rand_sample(int mode);
    in_t s;
    s.wind_speed = (mode == 0) ? 16'($urandom_range(0, 2000)) : 16'($urandom);
    s.wind_direction = ($urandom_range(0, 15) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 46079));
    return s;
  endfunction

  task automatic run_random(input int cnt);
    for (int i = 0; i < cnt; i++) queue_sample(rand_sample($urandom_range(0, 1)));
    wait_idle();
  endtask

  // stimulus
  initial begin
    logic [7:0] lens [6] = '{8'd3, 8'd1, 8'd0, 8'd255, 8'd17, 8'd200};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // extremes under the reset window length
    queue_sample('{16'd0, 16'd0});
    queue_sample('{16'd0, 16'd23040});
    queue_sample('{16'hffff, 16'd46079});
    queue_sample('{16'hffff, 16'd46080});
    queue_sample('{16'hffff, 16'hffff});
    queue_sample('{16'd256, 16'd11520});
    queue_sample('{16'd256, 16'd34560});
    queue_sample('{16'd256, 16'd0});
    queue_sample('{16'd256, 16'd23040});
    queue_sample('{16'h5555, 16'haaaa});
    queue_sample('{16'haaaa, 16'h5555});
    // pause until the core has answered everything sent so far
    while (sample_q.size() > 6) @(posedge clk);
    hold_send = 1'b1;
    @(posedge clk);
    while (in_valid || stats_q.size() > 0) @(posedge clk);
    hold_send = 1'b0;
    wait_idle();
    // zero length acts as one, and a cancelling pair gives a zero vector
    write_len(8'd0);
    queue_sample('{16'd100, 16'd0});
    wait_idle();
    write_len(8'd2);
    queue_sample('{16'd100, 16'd23040});
    wait_idle();
    run_random(60);
    foreach (lens[i]) begin
      write_len(lens[i]);
      run_random(60);
    end
    calm = 1'b1;
    write_len(8'd50);
    run_random(30);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
